// File: rtl/numlit_pkg.sv
// numlit_pkg: types and character constants for the numeric literal recognizer
// no dependencies; used by numlit_step and numeric_literal_recognizer
`default_nettype none

package numlit_pkg;

    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UPPER_E = 8'h45;
    localparam logic [7:0] CHAR_LOWER_E = 8'h65;

    typedef enum logic [7:0] {
        PH_START   = 8'b0000_0001,
        PH_SIGN    = 8'b0000_0010,
        PH_INT     = 8'b0000_0100,
        PH_FRAC    = 8'b0000_1000,
        PH_EXP     = 8'b0001_0000,
        PH_EXPSIGN = 8'b0010_0000,
        PH_EXPDIG  = 8'b0100_0000,
        PH_DEAD    = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        phase_t phase;
        logic   digit_seen;
        logic   integer_ok;
        logic   number_ok;
    } step_res_t;

endpackage

`default_nettype wire

// File: rtl/numlit_if.sv
// numlit_in_if, numlit_out_if: valid/ready channels for byte beats and verdict beats
// no dependencies
`default_nettype none

interface numlit_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       final_char;

    modport source (output valid, output char_code, output final_char, input ready);
    modport sink (input valid, input char_code, input final_char, output ready);
endinterface

interface numlit_out_if;
    logic valid;
    logic ready;
    logic integer_ok;
    logic number_ok;
    logic token_end;

    modport source (output valid, output integer_ok, output number_ok, output token_end,
                     input ready);
    modport sink (input valid, input integer_ok, input number_ok, input token_end,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/numlit_step.sv
// numlit_step: next parse phase and verdict flags for one byte
// depends on numlit_pkg
`default_nettype none

module numlit_step (
    input  wire numlit_pkg::phase_t    phase,
    input  wire logic                  digit_seen,
    input  wire logic [7:0]            char_code,
    output numlit_pkg::step_res_t      res
);

    logic               is_digit;
    logic               is_sign;
    logic               is_exp;
    logic               is_dot;
    numlit_pkg::phase_t ph_next;
    logic               seen_next;

    assign is_digit = (char_code >= numlit_pkg::CHAR_ZERO) &&
                      (char_code <= numlit_pkg::CHAR_NINE);
    assign is_sign  = (char_code == numlit_pkg::CHAR_PLUS) ||
                      (char_code == numlit_pkg::CHAR_MINUS);
    assign is_exp   = (char_code == numlit_pkg::CHAR_UPPER_E) ||
                      (char_code == numlit_pkg::CHAR_LOWER_E);
    assign is_dot   = (char_code == numlit_pkg::CHAR_DOT);

    always_comb
    begin
        ph_next   = numlit_pkg::PH_DEAD;
        seen_next = digit_seen;
        case (phase)
            numlit_pkg::PH_START:
            begin
                if (is_sign)
                    ph_next = numlit_pkg::PH_SIGN;
                else if (is_digit)
                begin
                    ph_next   = numlit_pkg::PH_INT;
                    seen_next = 1'b1;
                end
                else if (is_dot)
                    ph_next = numlit_pkg::PH_FRAC;
            end
            numlit_pkg::PH_SIGN:
            begin
                if (is_digit)
                begin
                    ph_next   = numlit_pkg::PH_INT;
                    seen_next = 1'b1;
                end
                else if (is_dot)
                    ph_next = numlit_pkg::PH_FRAC;
            end
            numlit_pkg::PH_INT:
            begin
                if (is_digit)
                    ph_next = numlit_pkg::PH_INT;
                else if (is_dot)
                    ph_next = numlit_pkg::PH_FRAC;
                else if (is_exp)
                    ph_next = numlit_pkg::PH_EXP;
            end
            numlit_pkg::PH_FRAC:
            begin
                if (is_digit)
                begin
                    ph_next   = numlit_pkg::PH_FRAC;
                    seen_next = 1'b1;
                end
                else if (is_exp && digit_seen)
                    ph_next = numlit_pkg::PH_EXP;
            end
            numlit_pkg::PH_EXP:
            begin
                if (is_sign)
                    ph_next = numlit_pkg::PH_EXPSIGN;
                else if (is_digit)
                    ph_next = numlit_pkg::PH_EXPDIG;
            end
            numlit_pkg::PH_EXPSIGN,
            numlit_pkg::PH_EXPDIG:
            begin
                if (is_digit)
                    ph_next = numlit_pkg::PH_EXPDIG;
            end
            default:
            begin
                ph_next = numlit_pkg::PH_DEAD;
            end
        endcase
    end

    assign res.phase      = ph_next;
    assign res.digit_seen = seen_next;
    assign res.integer_ok = (ph_next == numlit_pkg::PH_INT);
    assign res.number_ok  = (ph_next == numlit_pkg::PH_INT) ||
                            ((ph_next == numlit_pkg::PH_FRAC) && seen_next) ||
                            (ph_next == numlit_pkg::PH_EXPDIG);

endmodule

`default_nettype wire

// File: rtl/numeric_literal_recognizer.sv
// numeric_literal_recognizer: top level, byte register, parse state and verdict register
// depends on numlit_pkg, numlit_if, numlit_step
//
// usage:
//   src_ch carries one byte of a text token per beat, with final_char set on the
//   last byte. res_ch returns one verdict beat per byte: integer_ok says the
//   prefix so far is a signed integer, number_ok says it is a decimal number
//   with optional exponent, token_end copies final_char.
//   a byte passes through the byte register, then the verdict register, before
//   its verdict beat is valid on res_ch.
//   throughput: one byte per cycle while res_ch is ready; the parse state is
//   updated from the byte register as each byte advances, so consecutive
//   bytes follow back to back.
//   stall: when res_ch is not ready the verdict register holds and the byte
//   register still takes one more beat; src_ch.ready drops once both are full.
//   reset: rst_n clears both stages and puts the parse state at token start.
//   after a byte with final_char set the parse state returns to token start.
`default_nettype none

module numeric_literal_recognizer (
    input  wire logic   clk,
    input  wire logic   rst_n,
    numlit_in_if.sink   src_ch,
    numlit_out_if.source res_ch
);

    logic                  in_valid_reg;
    logic [7:0]            char_reg;
    logic                  final_reg;
    numlit_pkg::phase_t    phase_reg;
    logic                  seen_reg;
    logic                  out_valid_reg;
    logic                  integer_ok_reg;
    logic                  number_ok_reg;
    logic                  token_end_reg;
    logic                  out_free;
    logic                  stage_adv;
    numlit_pkg::step_res_t step_res;

    assign out_free     = !out_valid_reg || res_ch.ready;
    assign stage_adv    = in_valid_reg && out_free;
    assign src_ch.ready = !in_valid_reg || out_free;

    numlit_step u_step (
        .phase      (phase_reg),
        .digit_seen (seen_reg),
        .char_code  (char_reg),
        .res        (step_res)
    );

    // byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (src_ch.ready)
            in_valid_reg <= src_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (src_ch.valid && src_ch.ready)
        begin
            char_reg  <= src_ch.char_code;
            final_reg <= src_ch.final_char;
        end
    end

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= numlit_pkg::PH_START;
            seen_reg  <= 1'b0;
        end
        else if (stage_adv)
        begin
            if (final_reg)
            begin
                phase_reg <= numlit_pkg::PH_START;
                seen_reg  <= 1'b0;
            end
            else
            begin
                phase_reg <= step_res.phase;
                seen_reg  <= step_res.digit_seen;
            end
        end
    end

    // verdict register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv)
        begin
            integer_ok_reg <= step_res.integer_ok;
            number_ok_reg  <= step_res.number_ok;
            token_end_reg  <= final_reg;
        end
    end

    assign res_ch.valid      = out_valid_reg;
    assign res_ch.integer_ok = integer_ok_reg;
    assign res_ch.number_ok  = number_ok_reg;
    assign res_ch.token_end  = token_end_reg;

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for numeric_literal_recognizer, byte beats in, verdict beats out
// depends on numlit_pkg and numlit_if; predicts each verdict from its own copy of the parse state

module tb;

    typedef struct packed {
        logic integer_ok;
        logic number_ok;
        logic token_end;
    } verdict_t;

    localparam int HOLD_CYCLES = 64;

    logic clk;
    logic rst_n;

    numlit_in_if  src ();
    numlit_out_if res ();

    numeric_literal_recognizer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .src_ch (src.sink),
        .res_ch (res.source)
    );

    verdict_t           pending_verdicts[$];
    logic [7:0]         tok_bytes[$];
    numlit_pkg::phase_t tok_phase;
    logic               tok_digit_seen;
    int                 mismatch_count;
    int                 tx_idle_pct;
    int                 rx_idle_pct;
    int                 hold_req;
    int                 hold_seen;
    int                 hold_left;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [7:0] rand_digit();
        return numlit_pkg::CHAR_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic void append_byte(input logic [7:0] b);
        tok_bytes.insert(tok_bytes.size(), b);
    endfunction

    function automatic verdict_t predict_verdict(input logic [7:0] c, input logic fin);
        logic               dig;
        logic               sgn;
        logic               expo;
        logic               dot;
        numlit_pkg::phase_t nxt;
        verdict_t           v;
        dig  = (c >= numlit_pkg::CHAR_ZERO) && (c <= numlit_pkg::CHAR_NINE);
        sgn  = (c == numlit_pkg::CHAR_PLUS) || (c == numlit_pkg::CHAR_MINUS);
        expo = (c == numlit_pkg::CHAR_UPPER_E) || (c == numlit_pkg::CHAR_LOWER_E);
        dot  = (c == numlit_pkg::CHAR_DOT);
        nxt  = numlit_pkg::PH_DEAD;
        case (tok_phase)
            numlit_pkg::PH_START, numlit_pkg::PH_SIGN:
            begin
                if (sgn && tok_phase == numlit_pkg::PH_START)
                    nxt = numlit_pkg::PH_SIGN;
                else if (dig)
                begin
                    nxt = numlit_pkg::PH_INT;
                    tok_digit_seen = 1'b1;
                end
                else if (dot)
                    nxt = numlit_pkg::PH_FRAC;
            end
            numlit_pkg::PH_INT:
            begin
                if (dig)
                    nxt = numlit_pkg::PH_INT;
                else if (dot)
                    nxt = numlit_pkg::PH_FRAC;
                else if (expo)
                    nxt = numlit_pkg::PH_EXP;
            end
            numlit_pkg::PH_FRAC:
            begin
                if (dig)
                begin
                    nxt = numlit_pkg::PH_FRAC;
                    tok_digit_seen = 1'b1;
                end
                else if (expo && tok_digit_seen)
                    nxt = numlit_pkg::PH_EXP;
            end
            numlit_pkg::PH_EXP:
            begin
                if (sgn)
                    nxt = numlit_pkg::PH_EXPSIGN;
                else if (dig)
                    nxt = numlit_pkg::PH_EXPDIG;
            end
            numlit_pkg::PH_EXPSIGN, numlit_pkg::PH_EXPDIG:
            begin
                if (dig)
                    nxt = numlit_pkg::PH_EXPDIG;
            end
            default:
                nxt = numlit_pkg::PH_DEAD;
        endcase
        v.integer_ok = (nxt == numlit_pkg::PH_INT);
        v.number_ok  = (nxt == numlit_pkg::PH_INT) ||
                       (nxt == numlit_pkg::PH_FRAC && tok_digit_seen) ||
                       (nxt == numlit_pkg::PH_EXPDIG);
        v.token_end  = fin;
        tok_phase = nxt;
        if (fin)
        begin
            tok_phase      = numlit_pkg::PH_START;
            tok_digit_seen = 1'b0;
        end
        return v;
    endfunction

    // expected verdict per accepted byte
    always @(posedge clk)
    begin
        if (rst_n && src.valid && src.ready)
            pending_verdicts.insert(pending_verdicts.size(),
                                    predict_verdict(src.char_code, src.final_char));
    end

    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected verdict beat int=%b num=%b end=%b", $time,
                         res.integer_ok, res.number_ok, res.token_end);
            end
            else
            begin
                exp_v = pending_verdicts.pop_front();
                if (res.integer_ok !== exp_v.integer_ok)
                begin
                    mismatch_count++;
                    $display("%0t: integer_ok expected %b actual %b", $time,
                             exp_v.integer_ok, res.integer_ok);
                end
                if (res.number_ok !== exp_v.number_ok)
                begin
                    mismatch_count++;
                    $display("%0t: number_ok expected %b actual %b", $time,
                             exp_v.number_ok, res.number_ok);
                end
                if (res.token_end !== exp_v.token_end)
                begin
                    mismatch_count++;
                    $display("%0t: token_end expected %b actual %b", $time,
                             exp_v.token_end, res.token_end);
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            hold_seen = 0;
            hold_left = 0;
        end
        else
        begin
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else
                res.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] c, input logic fin);
        int gap;
        gap = 0;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            src.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src.valid      <= 1'b1;
        src.char_code  <= c;
        src.final_char <= fin;
        @(posedge clk);
        while (!src.ready)
            @(posedge clk);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    task automatic send_token();
        for (int i = 0; i < tok_bytes.size(); i++)
            send_byte(tok_bytes[i], i == tok_bytes.size() - 1);
    endtask

    // mostly well-formed numbers, some noise and broken forms
    task automatic build_random_token();
        int         kind;
        logic [7:0] specials[4];
        specials = '{numlit_pkg::CHAR_PLUS, numlit_pkg::CHAR_MINUS,
                     numlit_pkg::CHAR_DOT, numlit_pkg::CHAR_LOWER_E};
        tok_bytes.delete();
        kind = $urandom_range(9);
        if (kind < 2)
        begin
            repeat ($urandom_range(1, 6))
                append_byte(8'($urandom_range(255)));
        end
        else
        begin
            if ($urandom_range(2) == 0)
                append_byte($urandom_range(1) ? numlit_pkg::CHAR_PLUS
                                              : numlit_pkg::CHAR_MINUS);
            repeat ($urandom_range(0, 4))
                append_byte(rand_digit());
            if ($urandom_range(1))
            begin
                append_byte(numlit_pkg::CHAR_DOT);
                repeat ($urandom_range(0, 3))
                    append_byte(rand_digit());
            end
            if ($urandom_range(2) == 0)
            begin
                append_byte($urandom_range(1) ? numlit_pkg::CHAR_UPPER_E
                                              : numlit_pkg::CHAR_LOWER_E);
                if ($urandom_range(1))
                    append_byte($urandom_range(1) ? numlit_pkg::CHAR_PLUS
                                                  : numlit_pkg::CHAR_MINUS);
                repeat ($urandom_range(0, 3))
                    append_byte(rand_digit());
            end
            if (tok_bytes.size() == 0)
                append_byte(rand_digit());
            if (kind == 8)
                tok_bytes.insert($urandom_range(tok_bytes.size()),
                                 specials[$urandom_range(3)]);
            if (kind == 9)
                tok_bytes[$urandom_range(tok_bytes.size() - 1)] = 8'($urandom_range(255));
        end
    endtask

    task automatic wait_all_verdicts();
        @(posedge clk);
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_forms();
        send_string("0");
        send_string("+9");
        send_string("-1.5e+3");
        // exponent after a bare dot
        send_string(".e5");
        send_string("1.E9");
    endtask

    task automatic test_boundary_bytes();
        send_byte(8'h00, 1'b1);
        // rejected token stays rejected
        send_byte(8'hFF, 1'b0);
        send_byte(numlit_pkg::CHAR_NINE, 1'b1);
        send_string("/");
        send_string(":");
        send_string("e");
    endtask

    task automatic test_random_tokens(input int tx_pct, input int rx_pct, input int n_bytes);
        int sent;
        sent = 0;
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        while (sent < n_bytes)
        begin
            build_random_token();
            sent += tok_bytes.size();
            send_token();
        end
    endtask

    task automatic test_backpressure();
        int sent;
        sent = 0;
        tx_idle_pct = 0;
        hold_req <= hold_req + 1;
        while (sent < 30)
        begin
            build_random_token();
            sent += tok_bytes.size();
            send_token();
        end
    endtask

    task automatic test_drain_pause();
        tx_idle_pct = 10;
        rx_idle_pct <= 30;
        send_string("-0.25E-07");
        src.valid <= 1'b0;
        wait_all_verdicts();
        send_string("+.5e1");
        send_string("12e");
    endtask

    initial
    begin
        mismatch_count = 0;
        tx_idle_pct    = 24;
        rx_idle_pct    = 71;
        hold_req       = 0;
        tok_phase      = numlit_pkg::PH_START;
        tok_digit_seen = 1'b0;
        rst_n          <= 1'b0;
        src.valid      <= 1'b0;
        src.char_code  <= 8'h00;
        src.final_char <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_forms();
        test_boundary_bytes();
        test_random_tokens(24, 71, 170);
        test_backpressure();
        test_random_tokens(71, 24, 170);
        test_drain_pause();
        test_random_tokens(0, 0, 170);

        src.valid <= 1'b0;
        wait_all_verdicts();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0)
            $display("numeric_literal_recognizer verification clean");
        else
            $display("numeric_literal_recognizer verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("numeric_literal_recognizer verification failed");
        $finish;
    end

endmodule
